// ----- hdl/pulse_width_temp_frame_decoder_assert.svh -----
// Assertion macros shared by the frame decoder RTL.
`ifndef PULSE_WIDTH_TEMP_FRAME_DECODER_ASSERT_SVH
`define PULSE_WIDTH_TEMP_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PWTD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame decoder assertion failed");
`define PWTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame decoder assertion failed");
`else
`define PWTD_ASSERT(label, prop)
`define PWTD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/pwtd_pkg.sv -----
// Package with types, constants and codes of the pulse width frame decoder.
package pwtd_pkg;

    localparam int PULSE_BITS = 16;
    localparam int LEN_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W = 7;
    localparam int WORD_W = 32;
    localparam int RAW_W = 12;
    localparam int TEMP_W = 10;

    localparam logic [LEN_W-1:0] PULSE_MASK = LEN_W'((64'h1 << PULSE_BITS) - 64'h1);
    localparam logic [IDX_W-1:0] IDX_MAX = 7'd127;
    localparam logic [IDX_W-1:0] IDX_LAST_BEFORE_END = 7'd65;
    localparam logic [RAW_W-1:0] TEMP_NEG_LIMIT = 12'd3000;
    localparam logic [RAW_W:0] TEMP_BASE = 13'd4096;
    localparam logic [RAW_W-1:0] TEMP_MAX = 12'h258;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN = 2'd3;

    localparam logic [CFG_W-1:0] GAP_MAX_RESET = 16'd550;
    localparam logic [CFG_W-1:0] SHORT_MIN_RESET = 16'd1600;
    localparam logic [CFG_W-1:0] SHORT_MAX_RESET = 16'd2200;
    localparam logic [CFG_W-1:0] LONG_MIN_RESET = 16'd3000;

    typedef enum logic [2:0] {
        ST_OK,
        ST_COUNT,
        ST_GAP,
        ST_MARK,
        ST_ZERO,
        ST_PARITY,
        ST_FIXED,
        ST_RANGE
    } status_t;

    typedef struct packed {
        logic [CFG_W-1:0] gap_max;
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] long_min;
    } cfg_t;

    typedef struct packed {
        logic first;
        logic last;
        logic is_mark;
        logic is_gap;
        logic bit_val;
        logic mark_bad;
        logic gap_bad;
        logic count_ok;
    } tok_t;

    typedef struct packed {
        status_t status;
        logic [WORD_W-1:0] raw_word;
        logic [7:0] rolling_code;
        logic battery_ok;
        logic [TEMP_W-1:0] temp_tenths;
        logic temp_negative;
    } res_t;

endpackage

// ----- hdl/pwtd_if.sv -----
// Handshake interfaces for pulse words and result words.
interface pwtd_pulse_if;
    logic valid;
    logic ready;
    logic [pwtd_pkg::LEN_W-1:0] pulse_len;
    logic frame_start;
    logic frame_end;

    modport source (output valid, output pulse_len, output frame_start, output frame_end,
                    input ready);
    modport sink (input valid, input pulse_len, input frame_start, input frame_end,
                  output ready);
endinterface

interface pwtd_result_if;
    logic valid;
    logic ready;
    logic [2:0] status;
    logic [pwtd_pkg::WORD_W-1:0] raw_word;
    logic [7:0] rolling_code;
    logic battery_ok;
    logic [pwtd_pkg::TEMP_W-1:0] temp_tenths;
    logic temp_negative;

    modport source (output valid, output status, output raw_word, output rolling_code,
                    output battery_ok, output temp_tenths, output temp_negative,
                    input ready);
    modport sink (input valid, input status, input raw_word, input rolling_code,
                  input battery_ok, input temp_tenths, input temp_negative,
                  output ready);
endinterface

// ----- hdl/pwtd_front.sv -----
// Front end: accepts pulse words, counts pulses and classifies each one.
module pwtd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  pwtd_pkg::cfg_t  cfg,
    pwtd_pulse_if.sink      pulse_in,
    input  logic            full,
    output logic            push,
    output pwtd_pkg::tok_t  tok
);
    import pwtd_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] idx_base;
    logic [IDX_W:0]   num;
    logic [LEN_W-1:0] len;

    assign pulse_in.ready = !full;
    assign push = pulse_in.valid && !full;
    assign len = pulse_in.pulse_len & PULSE_MASK;
    assign idx_base = pulse_in.frame_start ? '0 : idx_reg;
    assign num = {1'b0, idx_base} + (IDX_W+1)'(1);

    always_comb
    begin
        tok.first = pulse_in.frame_start;
        tok.last = pulse_in.frame_end;
        tok.is_mark = (num >= 8'd2) && (num <= 8'd64) && !num[0];
        tok.is_gap = (num >= 8'd3) && (num <= 8'd65) && num[0];
        tok.bit_val = len > cfg.long_min;
        tok.mark_bad = (len < cfg.short_min) || (len > cfg.short_max);
        tok.gap_bad = len > cfg.gap_max;
        tok.count_ok = idx_base == IDX_LAST_BEFORE_END;
    end

    always_comb
    begin
        if (pulse_in.frame_end)
        begin
            idx_next = '0;
        end
        else if (idx_base < IDX_MAX)
        begin
            idx_next = num[IDX_W-1:0];
        end
        else
        begin
            idx_next = IDX_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (push)
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ----- hdl/pwtd_fifo.sv -----
// Two-entry queue of classified pulse tokens between front and back.
module pwtd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pwtd_pkg::tok_t push_tok,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output pwtd_pkg::tok_t head
);
    import pwtd_pkg::*;

    tok_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/pwtd_back.sv -----
// Back end: assembles frame bits, tracks errors and forms the result word.
module pwtd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           tok_valid,
    input  pwtd_pkg::tok_t tok,
    output logic           pop,
    input  logic           res_ready,
    output logic           res_valid,
    output pwtd_pkg::res_t res
);
    import pwtd_pkg::*;

    logic [WORD_W-1:0] shift_reg;
    logic [WORD_W-1:0] shift_next;
    status_t           err_reg;
    status_t           err_next;
    logic              pend_reg;
    logic              pend_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    res_t              res_reg;
    res_t              res_next;

    logic [WORD_W-1:0] shift_base;
    status_t           err_base;
    logic              pend_base;
    logic [WORD_W-1:0] word;
    status_t           err_now;
    logic [RAW_W-1:0]  raw;
    logic [RAW_W-1:0]  mag;
    logic              neg;
    status_t           status;
    logic              out_free;

    assign out_free = !res_valid_reg || res_ready;
    assign pop = tok_valid && (!tok.last || out_free);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_comb
    begin
        shift_base = tok.first ? '0 : shift_reg;
        err_base = tok.first ? ST_OK : err_reg;
        pend_base = tok.first ? 1'b0 : pend_reg;
        word = shift_base;
        err_now = err_base;
        pend_next = pend_base;
        if (tok.is_mark)
        begin
            word = {shift_base[WORD_W-2:0], tok.bit_val};
            if (!tok.bit_val && tok.mark_bad)
            begin
                pend_next = 1'b1;
            end
        end
        else if (tok.is_gap)
        begin
            if (err_base == ST_OK)
            begin
                if (tok.gap_bad)
                begin
                    err_now = ST_GAP;
                end
                else if (pend_base)
                begin
                    err_now = ST_MARK;
                end
            end
            pend_next = 1'b0;
        end
        if (tok.last)
        begin
            shift_next = '0;
            err_next = ST_OK;
            pend_next = 1'b0;
        end
        else
        begin
            shift_next = word;
            err_next = err_now;
        end
    end

    always_comb
    begin
        raw = word[19:8];
        neg = raw > TEMP_NEG_LIMIT;
        mag = neg ? RAW_W'(TEMP_BASE - {1'b0, raw}) : raw;
        if (!tok.count_ok)
        begin
            status = ST_COUNT;
        end
        else if (err_now != ST_OK)
        begin
            status = err_now;
        end
        else if (word == '0)
        begin
            status = ST_ZERO;
        end
        else if (^word)
        begin
            status = ST_PARITY;
        end
        else if (word[22:20] != 3'd0)
        begin
            status = ST_FIXED;
        end
        else if (mag > TEMP_MAX)
        begin
            status = ST_RANGE;
        end
        else
        begin
            status = ST_OK;
        end
        res_next.status = status;
        res_next.raw_word = word;
        if (status == ST_OK)
        begin
            res_next.rolling_code = word[31:24];
            res_next.battery_ok = word[23];
            res_next.temp_tenths = mag[TEMP_W-1:0];
            res_next.temp_negative = neg;
        end
        else
        begin
            res_next.rolling_code = '0;
            res_next.battery_ok = 1'b0;
            res_next.temp_tenths = '0;
            res_next.temp_negative = 1'b0;
        end
    end

    always_comb
    begin
        if (pop && tok.last)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && tok.last)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            err_reg <= ST_OK;
            pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                shift_reg <= shift_next;
                err_reg <= err_next;
                pend_reg <= pend_next;
            end
        end
    end

endmodule

// ----- hdl/pulse_width_temp_frame_decoder.sv -----
// A frame-end word is registered in the token queue and then in the output register.
// Throughput: one pulse word per cycle unless the queue is full; the two-entry token queue
// lets the front keep taking words while a finished result waits in the output register.
// Only a frame-end token waits in the back end, and only while the output register is full and not being read.
// Reset clears the pulse counter, bit shifter, error state, queue and output valid, and
// loads the default configuration registers.
module pulse_width_temp_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    pwtd_pulse_if.sink                        pulse_in,
    pwtd_result_if.source                     result_out,
    input  logic                              cfg_we,
    input  logic [pwtd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwtd_pkg::CFG_W-1:0]        cfg_value
);
    import pwtd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push;
    tok_t push_tok;
    logic full;
    logic tok_valid;
    tok_t head;
    logic pop;
    logic res_valid;
    res_t res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAP_MAX:   cfg_next.gap_max = cfg_value;
                CFG_SHORT_MIN: cfg_next.short_min = cfg_value;
                CFG_SHORT_MAX: cfg_next.short_max = cfg_value;
                CFG_LONG_MIN:  cfg_next.long_min = cfg_value;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_max <= GAP_MAX_RESET;
            cfg_reg.short_min <= SHORT_MIN_RESET;
            cfg_reg.short_max <= SHORT_MAX_RESET;
            cfg_reg.long_min <= LONG_MIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pwtd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pulse_in (pulse_in),
        .full     (full),
        .push     (push),
        .tok      (push_tok)
    );

    pwtd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .full     (full),
        .valid    (tok_valid),
        .head     (head)
    );

    pwtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (head),
        .pop       (pop),
        .res_ready (result_out.ready),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result_out.valid = res_valid;
    assign result_out.status = res.status;
    assign result_out.raw_word = res.raw_word;
    assign result_out.rolling_code = res.rolling_code;
    assign result_out.battery_ok = res.battery_ok;
    assign result_out.temp_tenths = res.temp_tenths;
    assign result_out.temp_negative = res.temp_negative;

`include "pulse_width_temp_frame_decoder_assert.svh"

    `PWTD_ASSERT(a_fail_fields_zero, !res_valid || res.status == ST_OK || (res.rolling_code == 8'd0 && !res.battery_ok && res.temp_tenths == '0 && !res.temp_negative))
    `PWTD_ASSERT(a_ok_temp_in_range, !res_valid || res.status != ST_OK || res.temp_tenths <= TEMP_W'(TEMP_MAX))
    `PWTD_ASSERT_NEXT(a_end_gives_result, pop && head.last, res_valid)

endmodule
